FILE: rtl/ppc_pkg.sv
// Package for the position P controller: beat types, widths, register map.
// No dependencies; used by every module of the block.
`default_nettype none

package ppc_pkg;

    localparam int unsigned DW       = 32;      // field and register width
    localparam int unsigned NUM_AX   = 3;       // x, y, z lanes
    localparam int unsigned ROOT_W   = 34;      // distance width
    localparam int unsigned RAD_W    = 2 * ROOT_W;  // radicand width
    localparam int unsigned QW       = 32;      // per-lane quotient width
    localparam int unsigned PROD_W   = 2 * DW;  // |e| * force magnitude
    localparam int unsigned ADDR_W   = 5;
    localparam int unsigned CTL_W    = DW + 1;  // near flag and velocity cap

    // Register indexes, byte address 4*index
    typedef enum logic [2:0] {
        REG_TARGET_X      = 3'd0,
        REG_TARGET_Y      = 3'd1,
        REG_TARGET_Z      = 3'd2,
        REG_LINEAR_GAIN   = 3'd3,
        REG_VELOCITY_CAP  = 3'd4,
        REG_FORCE_CAP     = 3'd5,
        REG_NEAR_DISTANCE = 3'd6
    } reg_idx_t;

    typedef struct packed {
        logic signed [DW-1:0] pos_x;
        logic signed [DW-1:0] pos_y;
        logic signed [DW-1:0] pos_z;
    } in_beat_t;

    typedef struct packed {
        logic                 near_target;
        logic signed [DW-1:0] force_x;
        logic signed [DW-1:0] force_y;
        logic signed [DW-1:0] force_z;
    } out_beat_t;

endpackage

`default_nettype wire

FILE: rtl/ppc_isqrt.sv
// Pipelined integer square root, one result bit per stage, with side data.
// Depends on ppc_pkg.
`default_nettype none

module ppc_isqrt #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [ppc_pkg::RAD_W-1:0]  radicand,
    input  logic [SIDE_W-1:0]          side_in,
    output logic [ppc_pkg::ROOT_W-1:0] root,
    output logic [SIDE_W-1:0]          side_out
);
    import ppc_pkg::*;

    localparam int unsigned REM_W = ROOT_W + 1;

    logic [REM_W-1:0]  rem_reg  [ROOT_W];
    logic [ROOT_W-1:0] root_reg [ROOT_W];
    logic [RAD_W-1:0]  rad_reg  [ROOT_W];
    logic [SIDE_W-1:0] side_reg [ROOT_W];

    for (genvar k = 0; k < ROOT_W; k++) begin : g_stage
        logic [REM_W-1:0]  rem_in;
        logic [ROOT_W-1:0] root_in;
        logic [RAD_W-1:0]  rad_in;
        logic [SIDE_W-1:0] side_k;
        logic [REM_W+1:0]  rem_sh;
        logic [REM_W+1:0]  trial;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in  = '0;
            assign root_in = '0;
            assign rad_in  = radicand;
            assign side_k  = side_in;
        end else begin : g_next
            assign rem_in  = rem_reg[k-1];
            assign root_in = root_reg[k-1];
            assign rad_in  = rad_reg[k-1];
            assign side_k  = side_reg[k-1];
        end

        // bring down two radicand bits, try root*4+1
        assign rem_sh = {rem_in, rad_in[RAD_W-1 -: 2]};
        assign trial  = {1'b0, root_in, 2'b01};
        assign ge     = (rem_sh >= trial);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? REM_W'(rem_sh - trial) : REM_W'(rem_sh);
                root_reg[k] <= {root_in[ROOT_W-2:0], ge};
                rad_reg[k]  <= {rad_in[RAD_W-3:0], 2'b00};
                side_reg[k] <= side_k;
            end
        end
    end

    assign root     = root_reg[ROOT_W-1];
    assign side_out = side_reg[ROOT_W-1];

endmodule

`default_nettype wire

FILE: rtl/ppc_div.sv
// One lane's pipelined restoring divider, one quotient bit per stage.
// Depends on ppc_pkg. Quotient must fit in QW bits (dividend < divisor*2^QW).
`default_nettype none

module ppc_div #(
    parameter int unsigned SIDE_W = 1
) (
    input  logic                       aclk,
    input  logic                       en,
    input  logic [ppc_pkg::PROD_W-1:0] dividend,
    input  logic [ppc_pkg::ROOT_W-1:0] divisor,
    input  logic [SIDE_W-1:0]          side_in,
    output logic [ppc_pkg::QW-1:0]     quotient,
    output logic [SIDE_W-1:0]          side_out
);
    import ppc_pkg::*;

    logic [ROOT_W-1:0] rem_reg  [QW];
    logic [QW-1:0]     low_reg  [QW];
    logic [QW-1:0]     quo_reg  [QW];
    logic [ROOT_W-1:0] dvs_reg  [QW];
    logic [SIDE_W-1:0] side_reg [QW];

    for (genvar k = 0; k < QW; k++) begin : g_stage
        logic [ROOT_W-1:0] rem_in;
        logic [QW-1:0]     low_in;
        logic [QW-1:0]     quo_in;
        logic [ROOT_W-1:0] dvs_in;
        logic [SIDE_W-1:0] side_k;
        logic [ROOT_W:0]   rem_sh;
        logic [ROOT_W:0]   dvs_ext;
        logic              ge;

        if (k == 0) begin : g_first
            assign rem_in = ROOT_W'(dividend[PROD_W-1:QW]);
            assign low_in = dividend[QW-1:0];
            assign quo_in = '0;
            assign dvs_in = divisor;
            assign side_k = side_in;
        end else begin : g_next
            assign rem_in = rem_reg[k-1];
            assign low_in = low_reg[k-1];
            assign quo_in = quo_reg[k-1];
            assign dvs_in = dvs_reg[k-1];
            assign side_k = side_reg[k-1];
        end

        // shift in next dividend bit, subtract when it fits
        assign rem_sh  = {rem_in, low_in[QW-1]};
        assign dvs_ext = {1'b0, dvs_in};
        assign ge      = (rem_sh >= dvs_ext);

        always_ff @(posedge aclk) begin
            if (en) begin
                rem_reg[k]  <= ge ? ROOT_W'(rem_sh - dvs_ext) : ROOT_W'(rem_sh);
                low_reg[k]  <= {low_in[QW-2:0], 1'b0};
                quo_reg[k]  <= {quo_in[QW-2:0], ge};
                dvs_reg[k]  <= dvs_in;
                side_reg[k] <= side_k;
            end
        end
    end

    assign quotient = quo_reg[QW-1];
    assign side_out = side_reg[QW-1];

endmodule

`default_nettype wire

FILE: rtl/position_p_controller.sv
// Top level of the saturated proportional position controller.
// Depends on ppc_pkg, ppc_isqrt (distance merge) and ppc_div (per-axis lanes).
//
//  channel   dir   handshake              payload
//  s_        in    s_valid / s_ready      ppc_pkg::in_beat_t  (pos_x, pos_y, pos_z)
//  m_        out   m_valid / m_ready      ppc_pkg::out_beat_t (near_target, force_x/y/z)
//  APB       in    psel/penable/pready    7 x 32-bit registers at 4*index
//
// One beat in and one beat out per cycle while the output is not stalled; stages: error, square,
// sum, 34 square-root stages, gain, cap, product, 32 divider stages, output reg.
// Reset (aresetn low, synchronous) clears all valid bits and loads register defaults.
// The whole pipeline holds while a result waits in the output register unacknowledged.
`default_nettype none

module position_p_controller #(
    parameter int unsigned FRAC_BITS = 16
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  ppc_pkg::in_beat_t          s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output ppc_pkg::out_beat_t         m_data,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [ppc_pkg::ADDR_W-1:0] paddr,
    input  logic [ppc_pkg::DW-1:0]     pwdata,
    output logic [ppc_pkg::DW-1:0]     prdata,
    output logic                       pready
);
    import ppc_pkg::*;

    localparam longint unsigned ONE_Q = 64'd1 << FRAC_BITS;
    localparam logic [DW-1:0] RST_TX   = DW'(11 * ONE_Q);
    localparam logic [DW-1:0] RST_TY   = DW'(64'd0 - 4 * ONE_Q);
    localparam logic [DW-1:0] RST_TZ   = DW'((49 * ONE_Q + 5) / 10);
    localparam logic [DW-1:0] RST_GAIN = DW'((2 * ONE_Q + 5) / 10);
    localparam logic [DW-1:0] RST_VCAP = DW'((5 * ONE_Q + 50) / 100);
    localparam logic [DW-1:0] RST_FCAP = DW'((85 * ONE_Q + 500) / 1000);
    localparam logic [DW-1:0] RST_NEAR = DW'((6 * ONE_Q + 5) / 10);
    localparam int unsigned SQ_SIDE_W = NUM_AX * (DW + 1);
    localparam int unsigned GP_W      = DW + ROOT_W;   // gain * distance

    // ---------------- configuration registers ----------------
    logic [DW-1:0] target_x_reg, target_y_reg, target_z_reg;
    logic [DW-1:0] gain_reg, vcap_reg, fcap_reg, near_reg;
    reg_idx_t      cfg_idx;
    logic          cfg_wr;

    assign cfg_idx = reg_idx_t'(paddr[ADDR_W-1:2]);
    assign cfg_wr  = psel & penable & pwrite & pready;
    assign pready  = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            target_x_reg <= RST_TX;
            target_y_reg <= RST_TY;
            target_z_reg <= RST_TZ;
            gain_reg     <= RST_GAIN;
            vcap_reg     <= RST_VCAP;
            fcap_reg     <= RST_FCAP;
            near_reg     <= RST_NEAR;
        end else if (cfg_wr) begin
            case (cfg_idx)
                REG_TARGET_X:      target_x_reg <= pwdata;
                REG_TARGET_Y:      target_y_reg <= pwdata;
                REG_TARGET_Z:      target_z_reg <= pwdata;
                REG_LINEAR_GAIN:   gain_reg     <= pwdata;
                REG_VELOCITY_CAP:  vcap_reg     <= pwdata;
                REG_FORCE_CAP:     fcap_reg     <= pwdata;
                REG_NEAR_DISTANCE: near_reg     <= pwdata;
                default: ;
            endcase
        end
    end

    // read mux
    always_comb begin
        case (cfg_idx)
            REG_TARGET_X:      prdata = target_x_reg;
            REG_TARGET_Y:      prdata = target_y_reg;
            REG_TARGET_Z:      prdata = target_z_reg;
            REG_LINEAR_GAIN:   prdata = gain_reg;
            REG_VELOCITY_CAP:  prdata = vcap_reg;
            REG_FORCE_CAP:     prdata = fcap_reg;
            REG_NEAR_DISTANCE: prdata = near_reg;
            default:           prdata = '0;
        endcase
    end

    // ---------------- pipeline control ----------------
    logic       m_valid_reg;
    out_beat_t  m_data_reg;
    logic       en;

    assign en      = ~m_valid_reg | m_ready;
    assign s_ready = en;
    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    logic signed [DW-1:0] pos [NUM_AX];
    logic signed [DW-1:0] tgt [NUM_AX];
    assign pos[0] = s_data.pos_x;
    assign pos[1] = s_data.pos_y;
    assign pos[2] = s_data.pos_z;
    assign tgt[0] = target_x_reg;
    assign tgt[1] = target_y_reg;
    assign tgt[2] = target_z_reg;

    // ---------------- lanes: error and square ----------------
    logic              s1_val_reg, s2_val_reg, s3_val_reg;
    logic [DW-1:0]     s1_mag_reg [NUM_AX];
    logic              s1_neg_reg [NUM_AX];
    logic [PROD_W-1:0] s2_sq_reg  [NUM_AX];
    logic [DW-1:0]     s2_mag_reg [NUM_AX];
    logic              s2_neg_reg [NUM_AX];
    logic [RAD_W-1:0]  s3_sum_reg;
    logic [SQ_SIDE_W-1:0] s3_side_reg;

    for (genvar i = 0; i < NUM_AX; i++) begin : g_err
        logic signed [DW:0] err;
        assign err = {tgt[i][DW-1], tgt[i]} - {pos[i][DW-1], pos[i]};

        always_ff @(posedge aclk) begin
            if (en) begin
                s1_neg_reg[i] <= err[DW];
                s1_mag_reg[i] <= err[DW] ? DW'(-err) : DW'(err);
                s2_sq_reg[i]  <= PROD_W'(s1_mag_reg[i]) * PROD_W'(s1_mag_reg[i]);
                s2_mag_reg[i] <= s1_mag_reg[i];
                s2_neg_reg[i] <= s1_neg_reg[i];
            end
        end
    end

    // sum of squares, lanes merge into one radicand
    always_ff @(posedge aclk) begin
        if (en) begin
            s3_sum_reg  <= RAD_W'(s2_sq_reg[0]) + RAD_W'(s2_sq_reg[1])
                         + RAD_W'(s2_sq_reg[2]);
            s3_side_reg <= {s2_neg_reg[0], s2_mag_reg[0], s2_neg_reg[1], s2_mag_reg[1],
                            s2_neg_reg[2], s2_mag_reg[2]};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_val_reg <= 1'b0;
            s2_val_reg <= 1'b0;
            s3_val_reg <= 1'b0;
        end else if (en) begin
            s1_val_reg <= s_valid;
            s2_val_reg <= s1_val_reg;
            s3_val_reg <= s2_val_reg;
        end
    end

    // ---------------- distance ----------------
    logic [ROOT_W-1:0]    root_dist;
    logic [SQ_SIDE_W-1:0] sq_side;
    logic                 sq_val_reg [ROOT_W];

    ppc_isqrt #(.SIDE_W(SQ_SIDE_W)) u_isqrt (
        .aclk     (aclk),
        .en       (en),
        .radicand (s3_sum_reg),
        .side_in  (s3_side_reg),
        .root     (root_dist),
        .side_out (sq_side)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < ROOT_W; k++) sq_val_reg[k] <= 1'b0;
        end else if (en) begin
            sq_val_reg[0] <= s3_val_reg;
            for (int k = 1; k < ROOT_W; k++) sq_val_reg[k] <= sq_val_reg[k-1];
        end
    end

    // ---------------- gain, threshold and caps ----------------
    logic                 g1_val_reg, g2_val_reg, mu_val_reg;
    logic                 g1_near_reg, g2_near_reg, mu_near_reg;
    logic [GP_W-1:0]      g1_prod_reg;
    logic [ROOT_W-1:0]    g1_dist_reg, g2_dist_reg, mu_dist_reg;
    logic [SQ_SIDE_W-1:0] g1_side_reg, g2_side_reg;
    logic [DW-1:0]        g2_fm_reg, g2_dv_reg, mu_dv_reg;
    logic [DW:0]          p_sat;
    logic [PROD_W-1:0]    mu_prod_reg [NUM_AX];
    logic                 mu_neg_reg  [NUM_AX];

    // floor(gain*d) >> FRAC_BITS, saturated to 2^32
    assign p_sat = (|g1_prod_reg[GP_W-1:FRAC_BITS+DW]) ? {1'b1, {DW{1'b0}}}
                 : {1'b0, g1_prod_reg[FRAC_BITS+DW-1:FRAC_BITS]};

    always_ff @(posedge aclk) begin
        if (en) begin
            g1_near_reg <= (root_dist <= ROOT_W'(near_reg));
            g1_prod_reg <= GP_W'(gain_reg) * GP_W'(root_dist);
            g1_dist_reg <= root_dist;
            g1_side_reg <= sq_side;

            g2_near_reg <= g1_near_reg;
            g2_fm_reg   <= (p_sat < {1'b0, fcap_reg}) ? p_sat[DW-1:0] : fcap_reg;
            g2_dv_reg   <= (p_sat < {1'b0, vcap_reg}) ? p_sat[DW-1:0] : vcap_reg;
            g2_dist_reg <= g1_dist_reg;
            g2_side_reg <= g1_side_reg;

            mu_near_reg <= g2_near_reg;
            mu_dv_reg   <= g2_dv_reg;
            mu_dist_reg <= g2_dist_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            g1_val_reg <= 1'b0;
            g2_val_reg <= 1'b0;
            mu_val_reg <= 1'b0;
        end else if (en) begin
            g1_val_reg <= sq_val_reg[ROOT_W-1];
            g2_val_reg <= g1_val_reg;
            mu_val_reg <= g2_val_reg;
        end
    end

    // ---------------- lanes: |e|*fm / d ----------------
    logic [QW-1:0] quo     [NUM_AX];
    logic          quo_neg [NUM_AX];

    for (genvar i = 0; i < NUM_AX; i++) begin : g_lane
        localparam int unsigned OFS = (NUM_AX - 1 - i) * (DW + 1);
        always_ff @(posedge aclk) begin
            if (en) begin
                mu_prod_reg[i] <= PROD_W'(g2_side_reg[OFS +: DW]) * PROD_W'(g2_fm_reg);
                mu_neg_reg[i]  <= g2_side_reg[OFS + DW];
            end
        end

        ppc_div #(.SIDE_W(1)) u_div (
            .aclk     (aclk),
            .en       (en),
            .dividend (mu_prod_reg[i]),
            .divisor  (mu_dist_reg),
            .side_in  (mu_neg_reg[i]),
            .quotient (quo[i]),
            .side_out (quo_neg[i])
        );
    end

    // near flag and velocity cap ride alongside the dividers
    logic             dv_val_reg [QW];
    logic [CTL_W-1:0] dv_ctl_reg [QW];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < QW; k++) dv_val_reg[k] <= 1'b0;
        end else if (en) begin
            dv_val_reg[0] <= mu_val_reg;
            for (int k = 1; k < QW; k++) dv_val_reg[k] <= dv_val_reg[k-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            dv_ctl_reg[0] <= {mu_near_reg, mu_dv_reg};
            for (int k = 1; k < QW; k++) dv_ctl_reg[k] <= dv_ctl_reg[k-1];
        end
    end

    // ---------------- sign, upper cap, saturation ----------------
    function automatic logic [DW-1:0] shape_force(input logic [QW-1:0] q, input logic neg,
                                                  input logic [DW-1:0] dv);
        logic [DW-1:0] v;
        begin
            if (neg) begin
                if (q > {1'b1, {(QW-1){1'b0}}}) v = {1'b1, {(DW-1){1'b0}}};
                else                            v = DW'(~q + 1'b1);
            end else begin
                v = (q > dv) ? dv : q;
                if (v[DW-1]) v = {1'b0, {(DW-1){1'b1}}};
            end
            return v;
        end
    endfunction

    logic          out_near;
    logic [DW-1:0] out_dv;
    logic [DW-1:0] frc [NUM_AX];

    assign out_near = dv_ctl_reg[QW-1][DW];
    assign out_dv   = dv_ctl_reg[QW-1][DW-1:0];

    for (genvar i = 0; i < NUM_AX; i++) begin : g_shape
        assign frc[i] = out_near ? '0 : shape_force(quo[i], quo_neg[i], out_dv);
    end

    // output register
    always_ff @(posedge aclk) begin
        if (en) begin
            m_data_reg.near_target <= out_near;
            m_data_reg.force_x     <= frc[0];
            m_data_reg.force_y     <= frc[1];
            m_data_reg.force_z     <= frc[2];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (en) begin
            m_valid_reg <= dv_val_reg[QW-1];
        end
    end

`ifndef SYNTHESIS
    a_hold_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.near_target) |->
        (m_data.force_x == '0 && m_data.force_y == '0 && m_data.force_z == '0))
        else $error("hold beat carries nonzero force");

    a_vcap: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_data.near_target) |->
        ($signed({1'b0, m_data.force_x}) <= $signed({1'b0, vcap_reg}) || m_data.force_x[DW-1]))
        else $error("x force above velocity cap");

    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_data)))
        else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
